FILE: hdl/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
// Used by hcbp_packer, huffman_code_bit_packer_top and the testbench; depends on nothing.
package hcbp_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_ENCODE = 2'd1;
    localparam logic [1:0] ACT_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  symbol;
        logic [31:0] code_bits;
        logic [5:0]  code_length;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    // Command from the table front end to the packer.
    typedef struct packed {
        logic encode;
        logic flush;
    } pk_cmd_t;

endpackage

FILE: hdl/hcbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/hcbp_packer.sv
// Bit packer: merges a code word into the pending byte and emits full bytes, or on a
// flush the pending byte, through an output register. Depends on hcbp_pkg.
module hcbp_packer #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
    localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32,
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hcbp_pkg::pk_cmd_t   cmd,
    input  logic [CODE_W-1:0]   code,
    input  logic [LEN_W-1:0]    len,
    output logic                busy,
    output logic                result_valid,
    input  logic                result_stall,
    output hcbp_pkg::result_t   result
);
    import hcbp_pkg::*;

    localparam int WIN_W = MAX_CODE_LEN + 8;
    localparam int SH_W  = $clog2(WIN_W + 1);
    localparam int TOT_W = $clog2(WIN_W);
    localparam int CNT_W = $clog2((MAX_CODE_LEN + 7) / 8 + 1);

    localparam logic PK_IDLE = 1'b0;
    localparam logic PK_EMIT = 1'b1;

    logic             state_reg, state_next;
    logic [7:0]       pending_reg, pending_next;
    logic [2:0]       bf_reg, bf_next;
    logic [WIN_W-1:0] win_reg, win_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       rem_reg, rem_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic [SH_W-1:0]  sh;
    logic [TOT_W-1:0] total;
    logic             slot_free;

    assign sh    = SH_W'(WIN_W) - SH_W'(bf_reg) - SH_W'(len);
    assign total = TOT_W'(bf_reg) + TOT_W'(len);
    assign slot_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next     = state_reg;
        pending_next   = pending_reg;
        bf_next        = bf_reg;
        win_next       = win_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        case (state_reg)
            PK_IDLE:
            begin
                if (cmd.encode)
                begin
                    // Place the code right under the filled bits of the pending byte.
                    win_next   = {pending_reg, {(WIN_W-8){1'b0}}}
                                 | (WIN_W'(code) << sh);
                    cnt_next   = CNT_W'(total >> 3);
                    rem_next   = total[2:0];
                    state_next = PK_EMIT;
                end
                else if (cmd.flush)
                begin
                    win_next   = {pending_reg, {(WIN_W-8){1'b0}}};
                    cnt_next   = CNT_W'(1);
                    rem_next   = 3'd0;
                    state_next = PK_EMIT;
                end
            end
            PK_EMIT:
            begin
                if (cnt_reg == '0)
                begin
                    // Leftover bits become the new pending byte.
                    pending_next = win_reg[WIN_W-1 -: 8];
                    bf_next      = rem_reg;
                    state_next   = PK_IDLE;
                end
                else if (slot_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next.out_byte = win_reg[WIN_W-1 -: 8];
                    out_next.last     = (cnt_reg == CNT_W'(1));
                    win_next          = win_reg << 8;
                    cnt_next          = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                state_next = PK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PK_IDLE;
            pending_reg   <= 8'd0;
            bf_reg        <= 3'd0;
            cnt_reg       <= '0;
            rem_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            bf_reg        <= bf_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        out_reg <= out_next;
    end

    assign busy         = (state_reg == PK_EMIT);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_cmd_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.encode || cmd.flush) |-> state_reg == PK_IDLE)
        else $error("packer command while busy");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.encode && cmd.flush))
        else $error("encode and flush together");

    a_pending_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == PK_IDLE |-> (pending_reg & (8'hFF >> bf_reg)) == 8'd0)
        else $error("pending byte has bits below the fill point");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PK_EMIT && cnt_reg == '0) |=> state_reg == PK_IDLE)
        else $error("packer did not return to idle");

endmodule

FILE: hdl/huffman_code_bit_packer_top.sv
// Channel   | Direction | Handshake                  | Payload
// item      | in        | item_valid / item_stall     | hcbp_pkg::item_t
// result    | out       | result_valid / result_stall | hcbp_pkg::result_t
//
// A load writes one code table entry. An encode reads the code table, then
// passes each emitted byte through the output register, then writes back
// the leftover bits. A flush emits the pending byte through the same register.
// The code table RAM is not cleared by reset; pending bits clear at once.
// A stall on result holds the packer; item_stall stays high until it finishes.
// Top level of the Huffman code bit packer. Depends on hcbp_pkg, hcbp_ram
// and hcbp_packer.
module huffman_code_bit_packer_top #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  hcbp_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output hcbp_pkg::result_t result
);
    import hcbp_pkg::*;

    localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int ADDR_W = $clog2(SYMBOL_COUNT);
    localparam int ENT_W  = CODE_W + LEN_W;

    logic              accept;
    logic              sym_ok;
    logic              lookup_reg;
    logic              pk_busy;
    logic [5:0]        len_sat;
    logic [31:0]       len_mask;
    logic [31:0]       code_masked;
    logic              ram_we;
    logic              ram_re;
    logic [ENT_W-1:0]  ram_wdata;
    logic [ENT_W-1:0]  ram_rdata;
    pk_cmd_t           cmd;

    assign item_stall = lookup_reg || pk_busy;
    assign accept     = item_valid && !item_stall;
    assign sym_ok     = ({1'b0, item.symbol} < 9'(SYMBOL_COUNT));

    // Saturate the length and drop code bits above it.
    assign len_sat     = (item.code_length > 6'(MAX_CODE_LEN)) ? 6'(MAX_CODE_LEN)
                                                               : item.code_length;
    assign len_mask    = 32'(~(64'hFFFF_FFFF_FFFF_FFFF << len_sat));
    assign code_masked = item.code_bits & len_mask;
    assign ram_wdata   = {code_masked[CODE_W-1:0], LEN_W'(len_sat)};

    assign ram_we = accept && (item.action == ACT_LOAD) && sym_ok;
    assign ram_re = accept && (item.action == ACT_ENCODE) && sym_ok;

    hcbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_code_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item.symbol[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (item.symbol[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookup_reg <= 1'b0;
        end
        else
        begin
            lookup_reg <= ram_re;
        end
    end

    assign cmd.encode = lookup_reg;
    assign cmd.flush  = accept && (item.action == ACT_FLUSH);

    hcbp_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .code         (ram_rdata[ENT_W-1 -: CODE_W]),
        .len          (ram_rdata[LEN_W-1:0]),
        .busy         (pk_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

FILE: tb/tb_huffman_code_bit_packer_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for huffman_code_bit_packer_top: loads code words, encodes
// symbols and flushes, predicting every packed byte. Depends on hcbp_pkg and the RTL.
module tb_huffman_code_bit_packer_top;
    import hcbp_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS = 19;

    class byte_scoreboard;
        logic [31:0] code_tbl [256];
        logic [5:0]  len_tbl [256];
        logic [7:0]  pend;
        int          filled;
        result_t     owed_bytes [$];
        int          errors;

        function new();
            pend = '0;
            filled = 0;
            errors = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Predict the bytes that one accepted transfer produces.
        function void take_item(input item_t it);
            logic [31:0] cw;
            int          n;
            int          i;
            int          pos;
            result_t     r;
            result_t     fresh [$];
            case (it.action)
                ACT_LOAD:
                begin
                    code_tbl[it.symbol] = it.code_bits;
                    len_tbl[it.symbol] = (it.code_length > MAX_CODE_LEN_DEF) ?
                        6'(MAX_CODE_LEN_DEF) : it.code_length;
                end
                ACT_ENCODE:
                begin
                    cw = code_tbl[it.symbol];
                    n = len_tbl[it.symbol];
                    for (i = n; i > 0; i--)
                    begin
                        pos = i - 1;
                        if (pos < 32 && cw[pos])
                            pend[7 - filled] = 1'b1;
                        filled++;
                        if (filled == 8)
                        begin
                            r.out_byte = pend;
                            r.last = 1'b0;
                            fresh.push_back(r);
                            pend = '0;
                            filled = 0;
                        end
                    end
                    if (fresh.size() > 0)
                        fresh[fresh.size() - 1].last = 1'b1;
                    foreach (fresh[k])
                        owed_bytes.push_back(fresh[k]);
                end
                ACT_FLUSH:
                begin
                    r.out_byte = pend;
                    r.last = 1'b1;
                    owed_bytes.push_back(r);
                    pend = '0;
                    filled = 0;
                end
                default: ;
            endcase
        endfunction

        task check_byte(input result_t got);
            result_t want;
            if (owed_bytes.size() == 0)
            begin
                report($sformatf("unexpected byte %02h last %0b", got.out_byte, got.last));
            end
            else
            begin
                want = owed_bytes.pop_front();
                if (got.out_byte !== want.out_byte)
                    report($sformatf("out_byte got %02h want %02h",
                                     got.out_byte, want.out_byte));
                if (got.last !== want.last)
                    report($sformatf("last got %0b want %0b (byte %02h)",
                                     got.last, want.last, want.out_byte));
            end
        endtask
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    byte_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;
    bit  hold_done;
    int  hold_left;
    int  quiet;
    bit  sym_loaded [256];
    int  loaded_syms [$];

    huffman_code_bit_packer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic item_t mk(input logic [1:0] act, input logic [7:0] sym,
                                 input logic [31:0] code, input logic [5:0] len);
        item_t it;
        it.action = act;
        it.symbol = sym;
        it.code_bits = code;
        it.code_length = len;
        return it;
    endfunction

    function automatic void mark_loaded(input logic [7:0] sym);
        if (!sym_loaded[sym])
        begin
            sym_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endfunction

    // Mostly encodes of loaded symbols, with loads, flushes and some noise.
    function automatic item_t random_item();
        item_t it;
        int    pick;
        int    lsel;
        it = mk(ACT_NONE, 8'($urandom), $urandom, 6'($urandom));
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            it.action = ACT_LOAD;
            lsel = $urandom_range(9);
            if (lsel == 0)
                it.code_length = 6'd0;
            else if (lsel == 1)
                it.code_length = 6'($urandom_range(63, 33));
            else
                it.code_length = 6'($urandom_range(32, 1));
            mark_loaded(it.symbol);
        end
        else if (pick < 80)
        begin
            it.action = ACT_ENCODE;
            it.symbol = 8'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
        end
        else if (pick < 92)
        begin
            it.action = ACT_FLUSH;
        end
        return it;
    endfunction

    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic load_sym(input logic [7:0] sym, input logic [31:0] code,
                            input logic [5:0] len);
        mark_loaded(sym);
        send_item(mk(ACT_LOAD, sym, code, len));
    endtask

    // Predict on accepted input, check on accepted output.
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.take_item(item);
        if (rst_n && result_valid && !result_stall)
            sb.check_byte(result);
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when asked.
    initial
    begin
        result_stall <= 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial
    begin
        int   ph;
        int   n;
        item_t it;
        sb = new();
        quiet = 0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of length and code, empty flush, ignored action.
        load_sym(8'd0, 32'h0000_0000, 6'd0);
        load_sym(8'd255, 32'hFFFF_FFFF, 6'd32);
        load_sym(8'd1, 32'h0000_0001, 6'd1);
        load_sym(8'd2, 32'hA5A5_A5A5, 6'd63);
        load_sym(8'd128, 32'h0000_0005, 6'd3);
        send_item(mk(ACT_FLUSH, 8'd0, 32'd0, 6'd0));
        send_item(mk(ACT_ENCODE, 8'd0, 32'd0, 6'd0));
        send_item(mk(ACT_ENCODE, 8'd1, 32'd0, 6'd0));
        send_item(mk(ACT_ENCODE, 8'd255, 32'd0, 6'd0));
        send_item(mk(ACT_ENCODE, 8'd2, 32'hFFFF_FFFF, 6'd63));
        send_item(mk(ACT_ENCODE, 8'd128, 32'd0, 6'd0));
        send_item(mk(ACT_NONE, 8'd255, 32'hFFFF_FFFF, 6'd63));
        send_item(mk(ACT_FLUSH, 8'd0, 32'd0, 6'd0));
        send_item(mk(ACT_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63));
        send_item(mk(ACT_ENCODE, 8'd255, 32'd0, 6'd0));
        load_sym(8'd1, 32'hFFFF_FF00, 6'd8);
        send_item(mk(ACT_ENCODE, 8'd1, 32'd0, 6'd0));
        load_sym(8'd200, 32'h8000_0001, 6'd33);
        send_item(mk(ACT_ENCODE, 8'd200, 32'd0, 6'd0));
        send_item(mk(ACT_ENCODE, 8'd128, 32'd0, 6'd0));
        send_item(mk(ACT_FLUSH, 8'd0, 32'd0, 6'd0));

        for (ph = 0; ph < 5; ph++)
        begin
            // free run, long hold-off, sender idle, receiver stall, both
            case (ph)
                0, 1:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 79;
                    recv_stall_pct = 0;
                end
                3:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 79;
                end
                default:
                begin
                    send_idle_pct = 25;
                    recv_stall_pct = 25;
                end
            endcase
            if (ph == 1)
                hold_req = 1'b1;
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                it = random_item();
                send_item(it);
                if (it.action != ACT_NONE)
                    n++;
            end
        end
        item_valid <= 1'b0;

        while (sb.owed_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.owed_bytes.size() != 0)
            sb.report($sformatf("%0d expected bytes never arrived", sb.owed_bytes.size()));

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/hcbp_pkg.sv
hdl/hcbp_ram.sv
hdl/hcbp_packer.sv
hdl/huffman_code_bit_packer_top.sv
tb/tb_huffman_code_bit_packer_top.sv
